@@ src/cbr_pkg.sv @@
// ----------------------------------------------------------------------------
// cbr_pkg
// Shared types and fixed constants of the cover-fit bilinear resampler.
// ----------------------------------------------------------------------------
package cbr_pkg;

   // canvas geometry, fixed by the 10-bit canvas coordinates
   localparam int CANVAS    = 1024;
   localparam int CANVAS_SH = $clog2(CANVAS);
   localparam int SPAN      = 2 * CANVAS;
   localparam int FRAC_W    = $clog2(SPAN);
   localparam int COORD_W   = 10;
   localparam int SIZE_W    = 9;
   localparam int NX_W      = FRAC_W + COORD_W;

   // datapath widths
   localparam int CH_W  = 8;
   localparam int H_W   = CH_W + FRAC_W;
   localparam int V_W   = H_W + FRAC_W;
   localparam int P_W   = 2 * V_W;
   localparam int U_W   = 32;
   localparam int OUT_W = 16;
   localparam int Q_W   = OUT_W + 1;
   localparam int E_W   = U_W + Q_W;
   localparam int F_W   = Q_W + OUT_W;

   // result = floor((v_c * v_a + 255^2 * 2^(DIV_SH-1)) / (255^2 * 2^DIV_SH))
   localparam int DIV_SH = 4 * FRAC_W - OUT_W;
   localparam logic [OUT_W-1:0] FULL_SQ    = OUT_W'(65025);
   localparam logic [P_W:0]     ROUND_BIAS = (P_W + 1)'(65025) << (DIV_SH - 1);
   // floor(2^32 / 65025), quotient estimate is low by at most one
   localparam logic [Q_W-1:0]   RECIP      = Q_W'(66051);
   localparam logic [Q_W-1:0]   SAT_MAX    = Q_W'(65535);

   // queues
   localparam int OPQ_DEPTH = 4;
   localparam int RSP_DEPTH = 16;
   localparam int RSV_W     = $clog2(RSP_DEPTH + 1);

   // register port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = SIZE_W;

   typedef enum logic {
      KIND_WRITE = 1'b0,
      KIND_READ  = 1'b1
   } cbr_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SRC_WIDTH  = 1'b0,
      CSR_SRC_HEIGHT = 1'b1
   } cbr_csr_type;

   typedef struct packed {
      logic                kind;
      logic [CH_W-1:0]     src_col;
      logic [CH_W-1:0]     src_row;
      logic [CH_W-1:0]     red_in;
      logic [CH_W-1:0]     green_in;
      logic [CH_W-1:0]     blue_in;
      logic [CH_W-1:0]     alpha_in;
      logic [COORD_W-1:0]  out_col;
      logic [COORD_W-1:0]  out_row;
   } cbr_req_type;

   typedef struct packed {
      logic [OUT_W-1:0] red_out;
      logic [OUT_W-1:0] green_out;
      logic [OUT_W-1:0] blue_out;
   } cbr_rsp_type;

   // stored word: red in the low byte, alpha in the high byte
   typedef struct packed {
      logic [CH_W-1:0] alpha;
      logic [CH_W-1:0] blue;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] red;
   } cbr_pixel_type;

   // effective source size
   typedef struct packed {
      logic [SIZE_W-1:0] w;
      logic [SIZE_W-1:0] h;
   } cbr_geom_type;

   // classified operation passed from front to back
   typedef struct packed {
      logic                kind;
      logic [NX_W-1:0]     nx;
      logic [NX_W-1:0]     ny;
      logic [CH_W-1:0]     col;
      logic [CH_W-1:0]     row;
      cbr_pixel_type       pix;
   } cbr_op_type;

endpackage

@@ src/cbr_queue.sv @@
// ----------------------------------------------------------------------------
// cbr_queue
// Small register FIFO with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module cbr_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
      next_ptr = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
   endfunction

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ src/cbr_front.sv @@
// ----------------------------------------------------------------------------
// cbr_front
// Size registers, item classification and cover-fit source mapping.
// ----------------------------------------------------------------------------
module cbr_front import cbr_pkg::*; #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  req_push,
   input  logic                  req_full,
   input  cbr_req_type           req_data,
   output logic                  opq_push,
   output cbr_op_type            opq_op,
   output cbr_geom_type          geom
);

   localparam int W_CAP = (MAX_WIDTH < 511) ? MAX_WIDTH : 511;
   localparam int H_CAP = (MAX_HEIGHT < 511) ? MAX_HEIGHT : 511;
   localparam int W_RST = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
   localparam int H_RST = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;
   localparam int M_RST = (W_RST < H_RST) ? W_RST : H_RST;

   logic [SIZE_W-1:0] w_ff, w_in;
   logic [SIZE_W-1:0] h_ff, h_in;
   logic [SIZE_W-1:0] m_ff, m_in;
   logic [SIZE_W-1:0] dx_ff, dx_in;
   logic [SIZE_W-1:0] dy_ff, dy_in;
   logic              accept, in_store;
   logic [NX_W-2:0]   prod_x, prod_y;

   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] cap);
      if (v == '0) begin
         eff_size = SIZE_W'(1);
      end else if (v > cap) begin
         eff_size = cap;
      end else begin
         eff_size = v;
      end
   endfunction

   // offsets are kept ready so a request right after a write sees them
   always_comb begin
      w_in = w_ff;
      h_in = h_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SRC_WIDTH:  w_in = eff_size(csr_data, SIZE_W'(W_CAP));
            CSR_SRC_HEIGHT: h_in = eff_size(csr_data, SIZE_W'(H_CAP));
            default: ;
         endcase
      end
      m_in  = (w_in < h_in) ? w_in : h_in;
      dx_in = w_in - m_in;
      dy_in = h_in - m_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff  <= SIZE_W'(W_RST);
         h_ff  <= SIZE_W'(H_RST);
         m_ff  <= SIZE_W'(M_RST);
         dx_ff <= SIZE_W'(W_RST - M_RST);
         dy_ff <= SIZE_W'(H_RST - M_RST);
      end else begin
         w_ff  <= w_in;
         h_ff  <= h_in;
         m_ff  <= m_in;
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
   end

   assign geom.w = w_ff;
   assign geom.h = h_ff;

   assign accept   = req_push && !req_full;
   assign in_store = (int'(req_data.src_col) < MAX_WIDTH) &&
                     (int'(req_data.src_row) < MAX_HEIGHT);
   // writes outside the store are dropped here
   assign opq_push = accept && ((req_data.kind == KIND_READ) || in_store);

   assign prod_x = (NX_W - 1)'({req_data.out_col, 1'b0}) * (NX_W - 1)'(m_ff);
   assign prod_y = (NX_W - 1)'({req_data.out_row, 1'b0}) * (NX_W - 1)'(m_ff);

   always_comb begin
      opq_op.kind      = req_data.kind;
      opq_op.nx        = NX_W'(prod_x) + (NX_W'(dx_ff) << CANVAS_SH);
      opq_op.ny        = NX_W'(prod_y) + (NX_W'(dy_ff) << CANVAS_SH);
      opq_op.col       = req_data.src_col;
      opq_op.row       = req_data.src_row;
      opq_op.pix.red   = req_data.red_in;
      opq_op.pix.green = req_data.green_in;
      opq_op.pix.blue  = req_data.blue_in;
      opq_op.pix.alpha = req_data.alpha_in;
   end

endmodule

@@ src/cbr_back.sv @@
// ----------------------------------------------------------------------------
// cbr_back
// Banked frame store, bilinear interpolation and premultiply pipeline.
// ----------------------------------------------------------------------------
module cbr_back import cbr_pkg::*; #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  cbr_geom_type geom,
   input  logic         opq_empty,
   input  cbr_op_type   opq_op,
   output logic         opq_pop,
   input  logic         rsp_release,
   output logic         res_push,
   output cbr_rsp_type  res_data
);

   localparam int XW     = $clog2(MAX_WIDTH);
   localparam int YW     = $clog2(MAX_HEIGHT);
   localparam int HALF_W = (MAX_WIDTH + 1) / 2;
   localparam int HALF_H = (MAX_HEIGHT + 1) / 2;
   localparam int BCW    = (HALF_W > 1) ? $clog2(HALF_W) : 1;
   localparam int BRW    = (HALF_H > 1) ? $clog2(HALF_H) : 1;
   localparam int BAW    = BCW + BRW;
   localparam int BDEPTH = 1 << BAW;
   localparam int NCH    = 4;
   localparam int NCOL   = 3;

   // ---------------------------------------------------------------- issue
   logic [RSV_W-1:0]  rsv_ff, rsv_in;
   logic              head_read, issue, issue_read;
   logic [COORD_W-1:0] x0_raw, y0_raw;
   logic [SIZE_W-1:0] wm1, hm1, x0c, x1c, y0c, y1c;
   logic [XW-1:0]     col_even, col_odd, wr_col;
   logic [YW-1:0]     row_even, row_odd, wr_row;
   logic [BCW-1:0]    col_half [2];
   logic [BRW-1:0]    row_half [2];
   logic [BAW-1:0]    wr_addr;
   logic [1:0]        wr_bank;
   logic [BAW-1:0]    bank_addr [NCH];
   logic [NCH-1:0]    bank_we;
   logic [31:0]       rd_pix [NCH];

   assign head_read  = (opq_op.kind == KIND_READ);
   // a read only goes out when its result has a reserved slot
   assign issue      = !opq_empty && (!head_read || (rsv_ff < RSV_W'(RSP_DEPTH)));
   assign issue_read = issue && head_read;
   assign opq_pop    = issue;

   assign rsv_in = rsv_ff + RSV_W'(issue_read) - RSV_W'(rsp_release);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsv_ff <= '0;
      end else begin
         rsv_ff <= rsv_in;
      end
   end

   assign x0_raw = opq_op.nx[NX_W-1 -: COORD_W];
   assign y0_raw = opq_op.ny[NX_W-1 -: COORD_W];
   assign wm1    = geom.w - SIZE_W'(1);
   assign hm1    = geom.h - SIZE_W'(1);

   // neighbors clamped at the right and bottom edges
   always_comb begin
      x0c = (COORD_W'(wm1) < x0_raw) ? wm1 : x0_raw[SIZE_W-1:0];
      y0c = (COORD_W'(hm1) < y0_raw) ? hm1 : y0_raw[SIZE_W-1:0];
      x1c = (x0c == wm1) ? wm1 : x0c + SIZE_W'(1);
      y1c = (y0c == hm1) ? hm1 : y0c + SIZE_W'(1);
      col_even = XW'(x0c[0] ? x1c : x0c);
      col_odd  = XW'(x0c[0] ? x0c : x1c);
      row_even = YW'(y0c[0] ? y1c : y0c);
      row_odd  = YW'(y0c[0] ? y0c : y1c);
      col_half[0] = BCW'(col_even >> 1);
      col_half[1] = BCW'(col_odd >> 1);
      row_half[0] = BRW'(row_even >> 1);
      row_half[1] = BRW'(row_odd >> 1);
      wr_col  = XW'(opq_op.col);
      wr_row  = YW'(opq_op.row);
      wr_addr = {BRW'(wr_row >> 1), BCW'(wr_col >> 1)};
      wr_bank = {opq_op.row[0], opq_op.col[0]};
      for (int k = 0; k < NCH; k++) begin
         bank_addr[k] = head_read ? {row_half[k / 2], col_half[k % 2]} : wr_addr;
         bank_we[k]   = issue && !head_read && (wr_bank == 2'(k));
      end
   end

   // bank k holds row parity k[1] and column parity k[0]
   for (genvar k = 0; k < NCH; k++) begin : g_bank
      logic [31:0] mem_ff [BDEPTH];
      logic [31:0] rd_ff;

      always_ff @(posedge clock) begin
         if (bank_we[k]) begin
            mem_ff[bank_addr[k]] <= opq_op.pix;
         end
         rd_ff <= mem_ff[bank_addr[k]];
      end

      assign rd_pix[k] = rd_ff;
   end

   // ---------------------------------------------------------------- stage 1
   logic              s1_vld_ff;
   logic [FRAC_W-1:0] s1_rx_ff, s1_ry_ff;
   logic              s1_x0p_ff, s1_x1p_ff, s1_y0p_ff, s1_y1p_ff;

   always_ff @(posedge clock) begin
      s1_rx_ff  <= opq_op.nx[FRAC_W-1:0];
      s1_ry_ff  <= opq_op.ny[FRAC_W-1:0];
      s1_x0p_ff <= x0c[0];
      s1_x1p_ff <= x1c[0];
      s1_y0p_ff <= y0c[0];
      s1_y1p_ff <= y1c[0];
   end

   function automatic logic [31:0] pick(input logic [31:0] b0, input logic [31:0] b1,
                                        input logic [31:0] b2, input logic [31:0] b3,
                                        input logic yp, input logic xp);
      case ({yp, xp})
         2'b00:   pick = b0;
         2'b01:   pick = b1;
         2'b10:   pick = b2;
         default: pick = b3;
      endcase
   endfunction

   logic [31:0]       p00, p10, p01, p11;
   logic [FRAC_W:0]   wx0, wx1;
   logic [H_W-1:0]    h0_in [NCH];
   logic [H_W-1:0]    h1_in [NCH];

   always_comb begin
      p00 = pick(rd_pix[0], rd_pix[1], rd_pix[2], rd_pix[3], s1_y0p_ff, s1_x0p_ff);
      p10 = pick(rd_pix[0], rd_pix[1], rd_pix[2], rd_pix[3], s1_y0p_ff, s1_x1p_ff);
      p01 = pick(rd_pix[0], rd_pix[1], rd_pix[2], rd_pix[3], s1_y1p_ff, s1_x0p_ff);
      p11 = pick(rd_pix[0], rd_pix[1], rd_pix[2], rd_pix[3], s1_y1p_ff, s1_x1p_ff);
      wx0 = (FRAC_W + 1)'(SPAN) - (FRAC_W + 1)'(s1_rx_ff);
      wx1 = (FRAC_W + 1)'(s1_rx_ff);
      for (int c = 0; c < NCH; c++) begin
         h0_in[c] = H_W'(p00[CH_W*c +: CH_W]) * H_W'(wx0) +
                    H_W'(p10[CH_W*c +: CH_W]) * H_W'(wx1);
         h1_in[c] = H_W'(p01[CH_W*c +: CH_W]) * H_W'(wx0) +
                    H_W'(p11[CH_W*c +: CH_W]) * H_W'(wx1);
      end
   end

   // ---------------------------------------------------------------- stage 2
   logic              s2_vld_ff;
   logic [FRAC_W-1:0] s2_ry_ff;
   logic [H_W-1:0]    s2_h0_ff [NCH];
   logic [H_W-1:0]    s2_h1_ff [NCH];
   logic [FRAC_W:0]   wy0, wy1;
   logic [V_W-1:0]    v_in [NCH];

   always_ff @(posedge clock) begin
      s2_ry_ff <= s1_ry_ff;
      s2_h0_ff <= h0_in;
      s2_h1_ff <= h1_in;
   end

   always_comb begin
      wy0 = (FRAC_W + 1)'(SPAN) - (FRAC_W + 1)'(s2_ry_ff);
      wy1 = (FRAC_W + 1)'(s2_ry_ff);
      for (int c = 0; c < NCH; c++) begin
         v_in[c] = V_W'(s2_h0_ff[c]) * V_W'(wy0) + V_W'(s2_h1_ff[c]) * V_W'(wy1);
      end
   end

   // ---------------------------------------------------------------- stage 3
   logic           s3_vld_ff;
   logic [V_W-1:0] s3_v_ff [NCH];
   logic [P_W-1:0] prod_in [NCOL];

   always_ff @(posedge clock) begin
      s3_v_ff <= v_in;
   end

   // color times alpha, index NCH-1 is alpha
   always_comb begin
      for (int c = 0; c < NCOL; c++) begin
         prod_in[c] = P_W'(s3_v_ff[c]) * P_W'(s3_v_ff[NCH-1]);
      end
   end

   // ---------------------------------------------------------------- stage 4
   logic           s4_vld_ff;
   logic [P_W-1:0] s4_p_ff [NCOL];
   logic [P_W:0]   biased [NCOL];
   logic [U_W-1:0] u_in [NCOL];

   always_ff @(posedge clock) begin
      s4_p_ff <= prod_in;
   end

   always_comb begin
      for (int c = 0; c < NCOL; c++) begin
         biased[c] = (P_W + 1)'(s4_p_ff[c]) + ROUND_BIAS;
         u_in[c]   = biased[c][DIV_SH +: U_W];
      end
   end

   // ---------------------------------------------------------------- stage 5
   logic           s5_vld_ff;
   logic [U_W-1:0] s5_u_ff [NCOL];
   logic [E_W-1:0] e_in [NCOL];

   always_ff @(posedge clock) begin
      s5_u_ff <= u_in;
   end

   // divide by 255^2 through the reciprocal
   always_comb begin
      for (int c = 0; c < NCOL; c++) begin
         e_in[c] = E_W'(s5_u_ff[c]) * E_W'(RECIP);
      end
   end

   // ---------------------------------------------------------------- stage 6
   logic           s6_vld_ff;
   logic [U_W-1:0] s6_u_ff [NCOL];
   logic [E_W-1:0] s6_e_ff [NCOL];
   logic [Q_W-1:0] qe_in [NCOL];
   logic [F_W-1:0] f_in [NCOL];

   always_ff @(posedge clock) begin
      s6_u_ff <= s5_u_ff;
      s6_e_ff <= e_in;
   end

   always_comb begin
      for (int c = 0; c < NCOL; c++) begin
         qe_in[c] = s6_e_ff[c][U_W +: Q_W];
         f_in[c]  = F_W'(qe_in[c]) * F_W'(FULL_SQ);
      end
   end

   // ---------------------------------------------------------------- stage 7
   logic           s7_vld_ff;
   logic [U_W-1:0] s7_u_ff [NCOL];
   logic [Q_W-1:0] s7_qe_ff [NCOL];
   logic [F_W-1:0] s7_f_ff [NCOL];
   logic [U_W-1:0] rem [NCOL];
   logic [Q_W-1:0] quo [NCOL];
   logic [OUT_W-1:0] sat [NCOL];

   always_ff @(posedge clock) begin
      s7_u_ff  <= s6_u_ff;
      s7_qe_ff <= qe_in;
      s7_f_ff  <= f_in;
   end

   // estimate may be one low: fix with one compare
   always_comb begin
      for (int c = 0; c < NCOL; c++) begin
         rem[c] = s7_u_ff[c] - s7_f_ff[c][U_W-1:0];
         quo[c] = s7_qe_ff[c] + Q_W'(rem[c] >= U_W'(FULL_SQ));
         sat[c] = (quo[c] > SAT_MAX) ? SAT_MAX[OUT_W-1:0] : quo[c][OUT_W-1:0];
      end
   end

   assign res_push           = s7_vld_ff;
   assign res_data.red_out   = sat[0];
   assign res_data.green_out = sat[1];
   assign res_data.blue_out  = sat[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
         s7_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= issue_read;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff;
         s6_vld_ff <= s5_vld_ff;
         s7_vld_ff <= s6_vld_ff;
      end
   end

endmodule

@@ src/cover_bilinear_resample.sv @@
// ----------------------------------------------------------------------------
// cover_bilinear_resample
// Frame store with cover-fit bilinear resampling to premultiplied RGB.
// ----------------------------------------------------------------------------
//  channel   ports                          direction  transfer when
//  request   push, full, req_data           in         push & !full
//  result    empty, pop, rsp_data           out        pop & !empty
//  register  valid, ready, csr_index/data   in         valid & ready
//
//  One item per cycle sustained while result slots are free; pixel writes
//  and canvas reads may interleave freely. A read result passes the op
//  queue, then the 7-stage multiply/divide pipeline behind the banked frame
//  store, then the result queue. The 2x2 banked store returns all four
//  neighbors together in a single read.
//  Reset (synchronous) empties both queues and sets the size to 256 x 256.
//  A stalled result side holds 16 results; up to 4 more items then wait in
//  the op queue before full rises.
// ----------------------------------------------------------------------------
module cover_bilinear_resample import cbr_pkg::*; #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  cbr_req_type           req_data,
   output logic                  empty,
   input  logic                  pop,
   output cbr_rsp_type           rsp_data,
   input  logic                  valid,
   output logic                  ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic         opq_push, opq_pop, opq_empty;
   cbr_op_type   opq_in_op, opq_out_op;
   cbr_geom_type geom;
   logic         res_push, rsp_release;
   cbr_rsp_type  res_data;

   assign ready       = 1'b1;
   assign rsp_release = pop && !empty;

   cbr_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_push  (push),
      .req_full  (full),
      .req_data  (req_data),
      .opq_push  (opq_push),
      .opq_op    (opq_in_op),
      .geom      (geom)
   );

   cbr_queue #(
      .WIDTH ($bits(cbr_op_type)),
      .DEPTH (OPQ_DEPTH)
   ) u_op_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (opq_push),
      .push_data (opq_in_op),
      .full      (full),
      .pop       (opq_pop),
      .pop_data  (opq_out_op),
      .empty     (opq_empty)
   );

   cbr_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .geom        (geom),
      .opq_empty   (opq_empty),
      .opq_op      (opq_out_op),
      .opq_pop     (opq_pop),
      .rsp_release (rsp_release),
      .res_push    (res_push),
      .res_data    (res_data)
   );

   // never overflows: the back reserves a slot before each read
   cbr_queue #(
      .WIDTH ($bits(cbr_rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .full      (),
      .pop       (pop),
      .pop_data  (rsp_data),
      .empty     (empty)
   );

endmodule

@@ src/cbr_checker.sv @@
// ----------------------------------------------------------------------------
// cbr_checker
// Port-level checks of the resampler, bound to the top level.
// ----------------------------------------------------------------------------
module cbr_checker import cbr_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  push,
   input logic                  full,
   input cbr_req_type           req_data,
   input logic                  empty,
   input logic                  pop,
   input cbr_rsp_type           rsp_data,
   input logic                  valid,
   input logic                  ready,
   input logic [CSR_IDX_W-1:0]  csr_index,
   input logic [CSR_DATA_W-1:0] csr_data
);

   localparam int PW = 8;

   logic [PW-1:0] pend_ff, pend_in;
   logic          read_xfer, rsp_xfer;

   // reads transferred in but not yet transferred out
   assign read_xfer = push && !full && (req_data.kind == KIND_READ);
   assign rsp_xfer  = pop && !empty;
   assign pend_in   = pend_ff + PW'(read_xfer) - PW'(rsp_xfer);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_reset_state: assert property (@(posedge clock) reset |=> (empty && !full))
      else $error("queues not empty after reset");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      (pend_ff == '0) |-> empty)
      else $error("result shown with no read outstanding");

   a_not_same_cycle: assert property (@(posedge clock) disable iff (reset)
      (read_xfer && (pend_ff == '0)) |=> empty)
      else $error("result shown one cycle after its request");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("waiting result changed or vanished");

   // register channel is watched only for completeness of the port list
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      valid |-> (ready || $stable(csr_index) || $stable(csr_data)))
      else $error("register write refused");

endmodule

bind cover_bilinear_resample cbr_checker u_cbr_checker (
   .clock     (clock),
   .reset     (reset),
   .push      (push),
   .full      (full),
   .req_data  (req_data),
   .empty     (empty),
   .pop       (pop),
   .rsp_data  (rsp_data),
   .valid     (valid),
   .ready     (ready),
   .csr_index (csr_index),
   .csr_data  (csr_data)
);

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for cover_bilinear_resample. Pixel writes and canvas
// reads go in through the request queue under random idling. Every read
// result is checked in order against a fixed value or a bit-exact cover-fit
// bilinear model with its own copy of the frame store and size registers.
// ---------------------------------------------------------------------------
module tb_top import cbr_pkg::*; ();

   localparam int     HALF_NS      = 10;
   localparam int     STORE_W      = 256;
   localparam int     STORE_H      = 256;
   localparam int     STORE_PIX    = STORE_W * STORE_H;
   localparam int     RAND_ITEMS   = 1750;
   localparam int     NUM_PHASES   = 10;
   localparam int     PRESS_PHASE  = 4;
   localparam int     PRESS_READS  = 60;
   localparam int     DRAIN_CYCLES = 16;
   localparam int     LONG_HOLD    = 120;
   localparam longint LIMIT_NS     = 8_000_000;

   typedef enum logic [1:0] {ROW_WRITE, ROW_READ, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type kind;
      int           a;      // column, canvas column or register index
      int           b;      // row, canvas row or register value
      logic [31:0]  pix;    // alpha, blue, green, red
      logic         typed;
      cbr_rsp_type  want;
   } plan_row_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  push      = 1'b0;
   logic                  pop       = 1'b0;
   logic                  valid     = 1'b0;
   cbr_req_type           req_data  = '0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data  = '0;
   logic                  full;
   logic                  empty;
   logic                  ready;
   cbr_rsp_type           rsp_data;

   cover_bilinear_resample dut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .valid     (valid),
      .ready     (ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // shadow of the frame store and the size registers
   logic [31:0]       pixel_store   [STORE_PIX];
   bit                pixel_written [STORE_PIX];
   logic [SIZE_W-1:0] width_reg  = SIZE_W'(256);
   logic [SIZE_W-1:0] height_reg = SIZE_W'(256);

   cbr_rsp_type expected_pixels [$];
   string       field_name [3] = '{"red_out", "green_out", "blue_out"};

   int fail_count   = 0;
   int results_seen = 0;
   int writes_sent  = 0;
   int reads_sent   = 0;
   int reg_writes   = 0;
   bit quiet_tail   = 1'b0;
   bit steady_send  = 1'b0;
   bit hold_long    = 1'b0;

   always begin
      #(HALF_NS) clock = 1'b1;
      #(HALF_NS) clock = 1'b0;
   end

   function automatic int unsigned eff_dim(input logic [SIZE_W-1:0] r,
                                           input int unsigned lim);
      if (r == 0)
         return 1;
      return (r > lim) ? lim : int'(r);
   endfunction

   // store addresses of the four neighbors and the fractional weights
   function automatic void map_taps(input logic [COORD_W-1:0] tx, ty,
                                    output int unsigned tap [4],
                                    output int unsigned rx, ry);
      int unsigned w, h, m, nx, ny, x0, x1, y0, y1;
      w  = eff_dim(width_reg, STORE_W);
      h  = eff_dim(height_reg, STORE_H);
      m  = (w < h) ? w : h;
      nx = 2 * tx * m + CANVAS * (w - m);
      ny = 2 * ty * m + CANVAS * (h - m);
      x0 = nx / SPAN;
      rx = nx % SPAN;
      y0 = ny / SPAN;
      ry = ny % SPAN;
      x1 = x0 + 1;
      y1 = y0 + 1;
      if (x0 > w - 1) x0 = w - 1;
      if (x1 > w - 1) x1 = w - 1;
      if (y0 > h - 1) y0 = h - 1;
      if (y1 > h - 1) y1 = h - 1;
      tap[0] = y0 * STORE_W + x0;
      tap[1] = y0 * STORE_W + x1;
      tap[2] = y1 * STORE_W + x0;
      tap[3] = y1 * STORE_W + x1;
   endfunction

   function automatic cbr_rsp_type resample_pixel(input logic [COORD_W-1:0] tx, ty);
      int unsigned      tap [4];
      int unsigned      rx, ry;
      longint unsigned  c00, c10, c01, c11;
      longint unsigned  v [4];
      logic [127:0]     scale;
      logic [127:0]     quo;
      logic [OUT_W-1:0] chan [3];
      cbr_rsp_type      res;
      map_taps(tx, ty, tap, rx, ry);
      // 255^2 * (2*CANVAS)^4, the full-scale weight of color times alpha
      scale = 128'(65025) << (4 * FRAC_W);
      for (int c = 0; c < 4; c++) begin
         c00  = pixel_store[tap[0]][8*c +: 8];
         c10  = pixel_store[tap[1]][8*c +: 8];
         c01  = pixel_store[tap[2]][8*c +: 8];
         c11  = pixel_store[tap[3]][8*c +: 8];
         v[c] = (c00 * (SPAN - rx) + c10 * rx) * (SPAN - ry)
              + (c01 * (SPAN - rx) + c11 * rx) * ry;
      end
      for (int c = 0; c < 3; c++) begin
         // round half up, then clip at the 16-bit top
         quo     = (((128'(v[c]) * 128'(v[3])) << 17) + scale) / (scale << 1);
         chan[c] = (quo > 128'(65535)) ? 16'hFFFF : quo[OUT_W-1:0];
      end
      res.red_out   = chan[0];
      res.green_out = chan[1];
      res.blue_out  = chan[2];
      return res;
   endfunction

   function automatic cbr_req_type noisy_item(input cbr_kind_type k);
      logic [95:0] raw;
      cbr_req_type item;
      raw       = {$urandom, $urandom, $urandom};
      item      = raw[$bits(cbr_req_type)-1:0];
      item.kind = k;
      return item;
   endfunction

   function automatic logic [CH_W-1:0] pick_chan();
      int unsigned sel;
      sel = $urandom_range(0, 3);
      if (sel == 0)
         return '0;
      else if (sel == 1)
         return '1;
      return CH_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [COORD_W-1:0] pick_coord();
      int unsigned sel;
      sel = $urandom_range(0, 7);
      if (sel == 0)
         return '0;
      else if (sel == 1)
         return '1;
      return COORD_W'($urandom_range(0, CANVAS - 1));
   endfunction

   // lower both request sides and wait until the block has gone quiet
   task automatic settle();
      push  <= 1'b0;
      valid <= 1'b0;
      while (expected_pixels.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input cbr_csr_type idx, input logic [CSR_DATA_W-1:0] val);
      settle();
      valid     <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!ready);
      if (idx == CSR_SRC_WIDTH)
         width_reg = val;
      else
         height_reg = val;
      reg_writes++;
   endtask

   // offer one item and update the shadow state once it is taken
   task automatic send_item(input cbr_req_type item, input logic typed = 1'b0,
                            input cbr_rsp_type want = '0);
      valid <= 1'b0;
      if (!quiet_tail && !steady_send && $urandom_range(0, 5) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      push     <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (full);
      if (item.kind == KIND_READ) begin
         expected_pixels.push_back(typed ? want : resample_pixel(item.out_col, item.out_row));
         reads_sent++;
      end else begin
         pixel_store[{item.src_row, item.src_col}] =
            {item.alpha_in, item.blue_in, item.green_in, item.red_in};
         pixel_written[{item.src_row, item.src_col}] = 1'b1;
         writes_sent++;
      end
   endtask

   task automatic send_write(input int col, input int row);
      cbr_req_type item;
      item          = noisy_item(KIND_WRITE);
      item.src_col  = col[CH_W-1:0];
      item.src_row  = row[CH_W-1:0];
      item.red_in   = pick_chan();
      item.green_in = pick_chan();
      item.blue_in  = pick_chan();
      item.alpha_in = pick_chan();
      send_item(item);
   endtask

   // fill any unwritten neighbor first, so no read touches an empty entry
   task automatic send_read_seq(input bit skip_read);
      cbr_req_type item;
      int unsigned tap [4];
      int unsigned rx, ry;
      item         = noisy_item(KIND_READ);
      item.out_col = pick_coord();
      item.out_row = pick_coord();
      map_taps(item.out_col, item.out_row, tap, rx, ry);
      for (int i = 0; i < 4; i++)
         if (!pixel_written[tap[i]])
            send_write(tap[i] % STORE_W, tap[i] / STORE_W);
      if (!skip_read)
         send_item(item);
   endtask

   initial begin : stimulus
      plan_row_type plan [$];
      int           phase_w [NUM_PHASES] = '{256, 1, 0, 511, 7, 200, 3, 256, 40, 0};
      int           phase_h [NUM_PHASES] = '{256, 1, 0, 300, 13, 3, 200, 1, 40, 0};
      int           phase_end;
      int unsigned  sel, w, h;
      bit           pressed;
      cbr_req_type  item;

      pressed = 1'b0;
      plan.push_back('{ROW_WRITE, 0, 0, 32'hFFFF_FFFF, 1'b0, '0});
      plan.push_back('{ROW_WRITE, 1, 0, 32'hFFFF_FFFF, 1'b0, '0});
      plan.push_back('{ROW_WRITE, 0, 1, 32'hFFFF_FFFF, 1'b0, '0});
      plan.push_back('{ROW_WRITE, 1, 1, 32'hFFFF_FFFF, 1'b0, '0});
      // opaque white comes out one above full scale and clips
      plan.push_back('{ROW_READ, 0, 0, '0, 1'b1, 48'hFFFF_FFFF_FFFF});
      plan.push_back('{ROW_WRITE, 255, 255, 32'hFFFF_FFFF, 1'b0, '0});
      plan.push_back('{ROW_READ, 1023, 1023, '0, 1'b1, 48'hFFFF_FFFF_FFFF});
      plan.push_back('{ROW_WRITE, 255, 255, 32'hFF00_FF00, 1'b0, '0});
      plan.push_back('{ROW_READ, 1023, 1023, '0, 1'b1, 48'h0000_FFFF_0000});
      // zero size acts as a single pixel
      plan.push_back('{ROW_CSR, CSR_SRC_WIDTH, 0, '0, 1'b0, '0});
      plan.push_back('{ROW_CSR, CSR_SRC_HEIGHT, 0, '0, 1'b0, '0});
      plan.push_back('{ROW_READ, 1023, 0, '0, 1'b1, 48'hFFFF_FFFF_FFFF});
      plan.push_back('{ROW_WRITE, 0, 0, 32'h0001_80FF, 1'b0, '0});
      plan.push_back('{ROW_READ, 512, 512, '0, 1'b1, '0});
      plan.push_back('{ROW_WRITE, 0, 0, 32'h8032_64C8, 1'b0, '0});
      plan.push_back('{ROW_READ, 0, 1023, '0, 1'b0, '0});
      // oversize registers clip to the store size
      plan.push_back('{ROW_CSR, CSR_SRC_WIDTH, 511, '0, 1'b0, '0});
      plan.push_back('{ROW_CSR, CSR_SRC_HEIGHT, 300, '0, 1'b0, '0});
      plan.push_back('{ROW_READ, 1023, 1023, '0, 1'b1, 48'h0000_FFFF_0000});
      // wide image, cropped left and right
      plan.push_back('{ROW_CSR, CSR_SRC_WIDTH, 3, '0, 1'b0, '0});
      plan.push_back('{ROW_CSR, CSR_SRC_HEIGHT, 2, '0, 1'b0, '0});
      plan.push_back('{ROW_WRITE, 2, 0, 32'hFF20_4060, 1'b0, '0});
      plan.push_back('{ROW_WRITE, 2, 1, 32'h7F10_E0A0, 1'b0, '0});
      plan.push_back('{ROW_WRITE, 255, 0, 32'h0000_0000, 1'b0, '0});
      plan.push_back('{ROW_READ, 0, 0, '0, 1'b0, '0});
      plan.push_back('{ROW_READ, 1023, 1023, '0, 1'b0, '0});
      plan.push_back('{ROW_READ, 511, 700, '0, 1'b0, '0});

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         item = '0;
         case (plan[i].kind)
            ROW_CSR: begin
               write_reg(cbr_csr_type'(plan[i].a), CSR_DATA_W'(plan[i].b));
            end
            ROW_WRITE: begin
               item.kind    = KIND_WRITE;
               item.src_col = CH_W'(plan[i].a);
               item.src_row = CH_W'(plan[i].b);
               {item.alpha_in, item.blue_in, item.green_in, item.red_in} = plan[i].pix;
               send_item(item);
            end
            default: begin
               item.kind    = KIND_READ;
               item.out_col = COORD_W'(plan[i].a);
               item.out_row = COORD_W'(plan[i].b);
               send_item(item, plan[i].typed, plan[i].want);
            end
         endcase
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         // last phase: random sizes, no idling on either side
         if (p == NUM_PHASES - 1) begin
            quiet_tail = 1'b1;
            phase_w[p] = $urandom_range(0, 511);
            phase_h[p] = $urandom_range(0, 511);
         end
         write_reg(CSR_SRC_WIDTH, CSR_DATA_W'(phase_w[p]));
         write_reg(CSR_SRC_HEIGHT, CSR_DATA_W'(phase_h[p]));
         w = eff_dim(width_reg, STORE_W);
         h = eff_dim(height_reg, STORE_H);
         phase_end = writes_sent + reads_sent + RAND_ITEMS / NUM_PHASES;
         while (writes_sent + reads_sent < phase_end) begin
            if (p == PRESS_PHASE && !pressed && writes_sent + reads_sent > phase_end - 80) begin
               // result side stalls while reads keep coming, so full has to rise
               pressed     = 1'b1;
               steady_send = 1'b1;
               hold_long   = 1'b1;
               repeat (PRESS_READS) send_read_seq(1'b0);
               steady_send = 1'b0;
            end else begin
               sel = $urandom_range(0, 99);
               if (sel < 60)
                  send_read_seq(1'b0);
               else if (sel < 85)
                  send_write($urandom_range(0, w - 1), $urandom_range(0, h - 1));
               else if (sel < 95)
                  send_write($urandom_range(0, STORE_W - 1), $urandom_range(0, STORE_H - 1));
               else
                  send_read_seq(1'b1);
            end
         end
      end

      settle();
      $display("summary: %0d pixel writes, %0d canvas reads, %0d register writes",
               writes_sent, reads_sent, reg_writes);
      $display("summary: %0d results checked over %0d size phases incl. a long output stall",
               results_seen, NUM_PHASES);
      if (fail_count == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

   initial begin : result_sink
      forever begin
         @(posedge clock);
         if (hold_long) begin
            pop <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_long = 1'b0;
            pop <= 1'b1;
         end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            pop <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            pop <= 1'b1;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : result_check
      cbr_rsp_type want;
      if (!reset && pop && !empty) begin
         if (expected_pixels.size() == 0) begin
            $display("%0t: result transfer with nothing expected, actual %h", $time, rsp_data);
            fail_count++;
         end else begin
            want = expected_pixels.pop_front();
            results_seen++;
            for (int f = 0; f < 3; f++) begin
               if (rsp_data[47-16*f -: 16] !== want[47-16*f -: 16]) begin
                  $display("%0t: %s mismatch, expected %0d actual %0d", $time,
                           field_name[f], want[47-16*f -: 16], rsp_data[47-16*f -: 16]);
                  fail_count++;
               end
            end
         end
      end
   end

   initial begin : watchdog
      #(LIMIT_NS);
      $display("tb_top: errors");
      $finish;
   end

endmodule
